// ----- design/exs_pkg.sv -----
package exs_pkg;

  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // what a cell hands to its right neighbor during loading
  typedef struct packed {
    logic   valid;
    value_t value;
  } pass_t;

  // what a cell shows to its left neighbor during unloading
  typedef struct packed {
    logic   occ;
    value_t value;
  } slot_t;

endpackage

// ----- design/exs_cell.sv -----
module exs_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift,
  input  exs_pkg::pass_t pass_in,
  input  exs_pkg::slot_t right_in,
  output exs_pkg::pass_t pass_out,
  output exs_pkg::slot_t slot_out
);
  import exs_pkg::*;

  logic   occ_r, occ_nxt;
  value_t val_r, val_nxt;
  logic   pv_r, pv_nxt;
  value_t pval_r, pval_nxt;

  always_comb begin
    occ_nxt  = occ_r;
    val_nxt  = val_r;
    pv_nxt   = 1'b0;
    pval_nxt = pval_r;
    if (shift) begin
      // unload: take the neighbor's value, smallest moves toward cell 0
      occ_nxt = right_in.occ;
      val_nxt = right_in.value;
    end else if (pass_in.valid) begin
      if (!occ_r) begin
        occ_nxt = 1'b1;
        val_nxt = pass_in.value;
      end else if (pass_in.value < val_r) begin
        val_nxt  = pass_in.value;
        pv_nxt   = 1'b1;
        pval_nxt = val_r;
      end else begin
        pv_nxt   = 1'b1;
        pval_nxt = pass_in.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      pv_r  <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      pv_r  <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    pval_r <= pval_nxt;
  end

  assign pass_out.valid = pv_r;
  assign pass_out.value = pval_r;
  assign slot_out.occ   = occ_r;
  assign slot_out.value = val_r;

endmodule

// ----- design/exchange_sort_ascending.sv -----
// sorts a list of signed 32-bit values into ascending order
// input channel: one value per request, in_last marks the final value of a list;
// values are taken one per cycle while a list is loading and ripple through a row
// of MAX_LEN compare-and-swap cells, each keeping the smaller value
// values beyond MAX_LEN are dropped and out_overflow is set on every result of
// that list
// after the last value is taken, the block waits while the last inserted value
// finishes moving down the row, then the row shifts toward cell 0 and emits one
// result per cycle while the receiver takes them, smallest first, with
// out_last_res on the final result; in_ready stays low from the last value until
// the final result is moved to the output register; the list length sets the
// settle time
// a stalled receiver holds the row: results wait in the output register and
// nothing is lost; a new list may be loaded while the final result still waits
// reset empties the row and clears the list count and overflow flag
module exchange_sort_ascending #(
  parameter int MAX_LEN = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  exs_pkg::value_t       in_value,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output exs_pkg::value_t       out_value_res,
  output logic                  out_last_res,
  output logic                  out_overflow
);
  import exs_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  typedef enum logic [1:0] {ST_LOAD, ST_DRAIN, ST_OUT} state_t;

  state_t     state_r;
  logic [CNT_W-1:0] count_r, drain_r, rem_r;
  logic       ovf_r;
  logic       out_valid_r, out_last_r, out_ovf_r;
  value_t     out_value_r;

  logic       accept, full, take, shift;
  pass_t      pass_w [MAX_LEN+1];
  slot_t      slot_w [MAX_LEN+1];

  assign in_ready = (state_r == ST_LOAD);
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(MAX_LEN));
  assign take     = !out_valid_r || out_ready;
  assign shift    = (state_r == ST_OUT) && take;

  assign pass_w[0].valid  = accept && !full;
  assign pass_w[0].value  = in_value;
  assign slot_w[MAX_LEN].occ   = 1'b0;
  assign slot_w[MAX_LEN].value = '0;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    exs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (shift),
      .pass_in  (pass_w[i]),
      .right_in (slot_w[i+1]),
      .pass_out (pass_w[i+1]),
      .slot_out (slot_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      drain_r     <= '0;
      rem_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_LOAD: begin
          if (accept) begin
            if (full) begin
              ovf_r <= 1'b1;
            end else begin
              count_r <= count_r + CNT_W'(1);
            end
            if (in_last) begin
              drain_r <= '0;
              state_r <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          // wait until the last insertion has settled in the row
          if (drain_r == count_r) begin
            rem_r   <= count_r;
            state_r <= ST_OUT;
          end else begin
            drain_r <= drain_r + CNT_W'(1);
          end
        end
        ST_OUT: begin
          if (take) begin
            out_valid_r <= 1'b1;
            rem_r       <= rem_r - CNT_W'(1);
            if (rem_r == CNT_W'(1)) begin
              count_r <= '0;
              ovf_r   <= 1'b0;
              state_r <= ST_LOAD;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      out_value_r <= slot_w[0].value;
      out_last_r  <= (rem_r == CNT_W'(1));
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_last_res  = out_last_r;
  assign out_overflow  = out_ovf_r;

  // a result is only ever taken from an occupied head cell
  assert property (@(posedge clk) disable iff (!rst_n) shift |-> slot_w[0].occ)
    else $error("emitting from empty head cell");

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CNT_W'(MAX_LEN))
    else $error("list count beyond capacity");

  // the head of the row has no gap: cell 1 is occupied only while cell 0 is
  assert property (@(posedge clk) disable iff (!rst_n) slot_w[1].occ |-> slot_w[0].occ)
    else $error("gap at head of row");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && count_r == '0) |-> !slot_w[0].occ)
    else $error("row not empty at start of list");

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import exs_pkg::*;

  localparam int SORT_DEPTH  = 64;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 500;

  typedef struct {
    value_t value;
    logic   last;
    logic   ovf;
  } sorted_word_t;

  class sort_scoreboard;
    value_t       held[$];
    bit           truncated;
    sorted_word_t sorted_words[$];
    int           mismatches;
    int           checked;
    int           lists_done;
    int           lists_cut;
    int           values_in;

    function void note_request(value_t v, logic last);
      sorted_word_t w;
      value_t       t;
      values_in++;
      if (held.size() < SORT_DEPTH) begin
        held.push_back(v);
      end else begin
        truncated = 1;
      end
      if (last) begin
        // insertion sort, signed compare
        for (int i = 1; i < held.size(); i++) begin
          for (int j = i; j > 0 && held[j] < held[j-1]; j--) begin
            t = held[j];
            held[j] = held[j-1];
            held[j-1] = t;
          end
        end
        foreach (held[k]) begin
          w.value = held[k];
          w.last  = (k == held.size() - 1);
          w.ovf   = truncated;
          sorted_words.push_back(w);
        end
        lists_done++;
        if (truncated) lists_cut++;
        held.delete();
        truncated = 0;
      end
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, what);
    endfunction

    function void check_result(value_t v, logic l, logic o);
      sorted_word_t w;
      checked++;
      if (sorted_words.size() == 0) begin
        report($sformatf("unexpected result: value %0d last %0b overflow %0b", v, l, o));
      end else begin
        w = sorted_words.pop_front();
        if (w.value !== v || w.last !== l || w.ovf !== o) begin
          report($sformatf({"result %0d wrong: expected value %0d last %0b overflow %0b,",
                            " got value %0d last %0b overflow %0b"},
                           checked, w.value, w.last, w.ovf, v, l, o));
        end
      end
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  value_t in_value = '0;
  logic   in_last = 1'b0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  value_t out_value_res;
  logic   out_last_res;
  logic   out_overflow;

  sort_scoreboard sb = new();
  bit             sender_calm;
  bit             hold;
  int             cycles;

  exchange_sort_ascending #(.MAX_LEN(SORT_DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value_res(out_value_res),
    .out_last_res (out_last_res),
    .out_overflow (out_overflow)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, sb.sorted_words.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic value_t pick_value();
    value_t v;
    case ($urandom_range(0, 9))
      0: v = 32'sh8000_0000 + $urandom_range(0, 3);
      1: v = 32'sh7fff_ffff - $urandom_range(0, 3);
      2, 3: v = $signed($urandom_range(0, 8)) - 4;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_item(value_t v, logic last);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_request(v, last);
  endtask

  task automatic send_values(value_t vals[$]);
    sender_calm = ($urandom_range(0, 3) == 0);
    foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
  endtask

  task automatic send_random_list(int len);
    value_t vals[$];
    repeat (len) vals.push_back(pick_value());
    send_values(vals);
  endtask

  // receiver: random stalls, calm stretches, and the long hold-off below
  initial begin
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_result(out_value_res, out_last_res, out_overflow);
        if (calm_left > 0) begin
          calm_left--;
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 17);
          if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 40);
        end
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= rst_n && stall_left == 0 && !hold;
    end
  end

  initial begin
    while (sb.checked < 20) @(negedge clk);
    hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold = 1'b0;
  end

  initial begin
    int lens[$];
    int n_items;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single values at the extremes, mixed signs, duplicates, reverse order
    send_values('{32'sh7fff_ffff});
    send_values('{32'sh8000_0000});
    send_values('{32'sh0, -32'sd1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd1});
    send_values('{32'sd5, 32'sd5, -32'sd5, 32'sd5});
    send_values('{32'sd3, 32'sd2, 32'sd1, 32'sd0, -32'sd1, -32'sd2});
    send_values('{32'sh7fff_ffff, 32'sh8000_0000});

    // mostly short lists; a full list, one truncated on its last value,
    // and one truncated well past capacity
    lens = '{SORT_DEPTH, SORT_DEPTH + 1, SORT_DEPTH + $urandom_range(2, 8)};
    n_items = 0;
    for (int k = 0; n_items < 430; k++) begin
      int len;
      if (k % 9 == 4 && lens.size() > 0) begin
        len = lens.pop_front();
      end else if ($urandom_range(0, 5) == 0) begin
        len = $urandom_range(9, 24);
      end else begin
        len = $urandom_range(1, 8);
      end
      send_random_list(len);
      n_items += len;
    end
    in_valid <= 1'b0;

    while (sb.sorted_words.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("sorted %0d lists from %0d values (%0d lists over capacity), %0d results checked",
             sb.lists_done, sb.values_in, sb.lists_cut, sb.checked);
    if (sb.sorted_words.size() > 0 || sb.held.size() > 0) begin
      sb.report($sformatf("%0d results never arrived", sb.sorted_words.size()));
    end
    if (sb.mismatches > 10) $display("%0d failures in total", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
